>>> hw/rtl/palette_scaled_rgb565_blit_top_defines.svh
// assertion macros shared by the rtl
`ifndef PALETTE_SCALED_RGB565_BLIT_TOP_DEFINES_SVH
`define PALETTE_SCALED_RGB565_BLIT_TOP_DEFINES_SVH

`ifndef SYNTH
`define PSB_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error("same-cycle check failed");
`define PSB_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error("next-cycle check failed");
`else
`define PSB_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define PSB_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif

`endif

>>> hw/rtl/psb_pkg.sv
`default_nettype none

package psb_pkg;

	localparam int SRC_WIDTH       = 320;
	localparam int SRC_HEIGHT      = 200;
	localparam int PAL_DEPTH       = 256;
	localparam int PAL_AW          = $clog2(PAL_DEPTH);
	localparam int BYTES_PER_PIXEL = 2;

	localparam int IDX_W  = 8;
	localparam int COMP_W = 8;
	localparam int RGB_W  = 3 * COMP_W;
	localparam int SX_W   = 9;
	localparam int SY_W   = 8;
	localparam int ADDR_W = 27;
	localparam int PIX_W  = 16;

	localparam int SCALE_W = 16;
	localparam int OFS_W   = 20;
	localparam int SCR_W   = 13;
	localparam int PAN_W   = 12;
	localparam int LB_W    = 15;
	localparam int CFG_IDX_W  = 4;
	localparam int CFG_DATA_W = 20;

	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	localparam logic [SCALE_W-1:0] SCALE_RST  = SCALE_W'(256);
	localparam logic [SCR_W-1:0]   SCR_W_RST  = SCR_W'(320);
	localparam logic [SCR_W-1:0]   SCR_H_RST  = SCR_W'(200);
	localparam logic [LB_W-1:0]    LB_RST     = LB_W'(640);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SCALE      = 4'd0,
		REG_X_OFFSET   = 4'd1,
		REG_Y_OFFSET   = 4'd2,
		REG_SCR_WIDTH  = 4'd3,
		REG_SCR_HEIGHT = 4'd4,
		REG_PAN_X      = 4'd5,
		REG_PAN_Y      = 4'd6,
		REG_LINE_BYTES = 4'd7
	} cfg_reg_t;

	typedef enum logic {
		CMD_PAL_WRITE = 1'b0,
		CMD_PIXEL     = 1'b1
	} cmd_t;

	typedef struct packed {
		logic [SCALE_W-1:0] scale_q8;
		logic [OFS_W-1:0]   x_offset_q8;
		logic [OFS_W-1:0]   y_offset_q8;
		logic [SCR_W-1:0]   screen_width;
		logic [SCR_W-1:0]   screen_height;
		logic [PAN_W-1:0]   pan_x;
		logic [PAN_W-1:0]   pan_y;
		logic [LB_W-1:0]    line_bytes;
	} cfg_t;

	typedef struct packed {
		logic             is_pixel;
		logic             src_ok;
		logic             idx_ok;
		logic [IDX_W-1:0] idx;
		logic [RGB_W-1:0] rgb;
		logic [SX_W-1:0]  sx;
		logic [SY_W-1:0]  sy;
	} item_t;

	function automatic logic [PIX_W-1:0] pack565(input logic [RGB_W-1:0] rgb);
		logic [COMP_W-1:0] r;
		logic [COMP_W-1:0] g;
		logic [COMP_W-1:0] b;
		r = rgb[3*COMP_W-1:2*COMP_W];
		g = rgb[2*COMP_W-1:COMP_W];
		b = rgb[COMP_W-1:0];
		pack565 = {r[7:3], g[7:2], b[7:3]};
	endfunction

endpackage

`default_nettype wire

>>> hw/rtl/psb_ram.sv
`default_nettype none

module psb_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

>>> hw/rtl/psb_front.sv
`default_nettype none

module psb_front (
	input  wire logic                        in_valid,
	output      logic                        in_stall,
	input  wire logic                        cmd,
	input  wire logic [psb_pkg::IDX_W-1:0]   color_index,
	input  wire logic [psb_pkg::COMP_W-1:0]  red,
	input  wire logic [psb_pkg::COMP_W-1:0]  green,
	input  wire logic [psb_pkg::COMP_W-1:0]  blue,
	input  wire logic [psb_pkg::SX_W-1:0]    src_x,
	input  wire logic [psb_pkg::SY_W-1:0]    src_y,
	input  wire logic                        q_full,
	output      logic                        push,
	output      psb_pkg::item_t              push_item
);
	import psb_pkg::*;

	assign in_stall = q_full;
	assign push     = in_valid && !q_full;

	// classify: kind, source window, palette range
	always_comb begin
		push_item.is_pixel = (cmd_t'(cmd) == CMD_PIXEL);
		push_item.src_ok   = ({3'b0, src_x} < 12'(SRC_WIDTH)) &&
		                     ({4'b0, src_y} < 12'(SRC_HEIGHT));
		push_item.idx_ok   = ({1'b0, color_index} < 9'(PAL_DEPTH));
		push_item.idx      = color_index;
		push_item.rgb      = {red, green, blue};
		push_item.sx       = src_x;
		push_item.sy       = src_y;
	end

endmodule

`default_nettype wire

>>> hw/rtl/psb_queue.sv
`default_nettype none
`include "palette_scaled_rgb565_blit_top_defines.svh"

module psb_queue (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           push,
	input  wire psb_pkg::item_t push_item,
	output      logic           full,
	output      logic           not_empty,
	input  wire logic           pop,
	output      psb_pkg::item_t head
);
	import psb_pkg::*;

	item_t               entry_q [QDEPTH];
	logic [QPTR_W-1:0]   wr_ptr_q;
	logic [QPTR_W-1:0]   rd_ptr_q;
	logic [QCNT_W-1:0]   count_q;

	assign full      = (count_q == QCNT_W'(QDEPTH));
	assign not_empty = (count_q != '0);
	assign head      = entry_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_item;
		end
	end

	`PSB_ASSERT_IMP(a_count_bound, clk, arst_n, 1'b1, count_q <= QCNT_W'(QDEPTH))
	`PSB_ASSERT_NXT(a_full_holds, clk, arst_n, full && !pop, full)
	`PSB_ASSERT_NXT(a_pop_drains, clk, arst_n, (count_q == QCNT_W'(1)) && pop && !push, !not_empty)

endmodule

`default_nettype wire

>>> hw/rtl/psb_back.sv
`default_nettype none
`include "palette_scaled_rgb565_blit_top_defines.svh"

module psb_back (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire psb_pkg::cfg_t               cfg,
	input  wire logic                        q_valid,
	input  wire psb_pkg::item_t              head,
	output      logic                        pop,
	output      logic                        out_valid,
	input  wire logic                        out_stall,
	output      logic                        write_valid,
	output      logic [psb_pkg::ADDR_W-1:0]  byte_address,
	output      logic [psb_pkg::PIX_W-1:0]   pixel565
);
	import psb_pkg::*;

	logic advance;

	logic valid_s1;
	logic valid_s2;
	logic valid_s3;
	logic out_valid_q;

	logic              draw_s1;
	logic              idx_ok_s1;
	logic [24:0]       prod_x_s1;
	logic [23:0]       prod_y_s1;

	logic              draw_s2;
	logic [SCR_W-1:0]  fx_s2;
	logic [SCR_W-1:0]  fy_s2;
	logic [PIX_W-1:0]  pix_s2;

	logic              wv_s3;
	logic [ADDR_W-1:0] addr_x_s3;
	logic [ADDR_W-1:0] row_prod_s3;
	logic [PIX_W-1:0]  pix_s3;

	logic              write_valid_q;
	logic [ADDR_W-1:0] byte_address_q;
	logic [PIX_W-1:0]  pixel565_q;

	logic [RGB_W-1:0]  pal_rdata;
	logic [25:0]       sum_x;
	logic [24:0]       sum_y;
	logic [17:0]       fx;
	logic [16:0]       fy;
	logic              on_screen;
	logic [13:0]       col;
	logic [13:0]       row;
	logic [28:0]       row_prod;

	assign advance = !out_valid_q || !out_stall;
	assign pop     = advance && q_valid;

	psb_ram #(
		.WIDTH(RGB_W),
		.DEPTH(PAL_DEPTH)
	) u_palette (
		.clk  (clk),
		.we   (pop && !head.is_pixel && head.idx_ok),
		.waddr(head.idx[PAL_AW-1:0]),
		.wdata(head.rgb),
		.re   (advance),
		.raddr(head.idx[PAL_AW-1:0]),
		.rdata(pal_rdata)
	);

	// map into the framebuffer and clip
	always_comb begin
		sum_x     = 26'(prod_x_s1) + 26'(cfg.x_offset_q8);
		sum_y     = 25'(prod_y_s1) + 25'(cfg.y_offset_q8);
		fx        = sum_x[25:8];
		fy        = sum_y[24:8];
		on_screen = (fx < 18'(cfg.screen_width)) && (fy < 17'(cfg.screen_height));
		col       = 14'(fx_s2) + 14'(cfg.pan_x);
		row       = 14'(fy_s2) + 14'(cfg.pan_y);
		row_prod  = 29'(row) * 29'(cfg.line_bytes);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			valid_s3    <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (advance) begin
			valid_s1    <= pop;
			valid_s2    <= valid_s1;
			valid_s3    <= valid_s2;
			out_valid_q <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			draw_s1   <= head.is_pixel && head.src_ok;
			idx_ok_s1 <= head.idx_ok;
			prod_x_s1 <= 25'(head.sx) * 25'(cfg.scale_q8);
			prod_y_s1 <= 24'(head.sy) * 24'(cfg.scale_q8);

			draw_s2 <= draw_s1 && on_screen;
			fx_s2   <= fx[SCR_W-1:0];
			fy_s2   <= fy[SCR_W-1:0];
			pix_s2  <= idx_ok_s1 ? pack565(pal_rdata) : '0;

			wv_s3       <= draw_s2;
			addr_x_s3   <= ADDR_W'(col) * ADDR_W'(BYTES_PER_PIXEL);
			row_prod_s3 <= row_prod[ADDR_W-1:0];
			pix_s3      <= pix_s2;

			write_valid_q  <= wv_s3;
			byte_address_q <= wv_s3 ? addr_x_s3 + row_prod_s3 : '0;
			pixel565_q     <= wv_s3 ? pix_s3 : '0;
		end
	end

	assign out_valid    = out_valid_q;
	assign write_valid  = write_valid_q;
	assign byte_address = byte_address_q;
	assign pixel565     = pixel565_q;

	`PSB_ASSERT_IMP(a_drop_is_zero, clk, arst_n, out_valid_q && !write_valid_q, (byte_address_q == '0) && (pixel565_q == '0))
	`PSB_ASSERT_NXT(a_stall_holds_s1, clk, arst_n, valid_s1 && !advance, valid_s1 && $stable(prod_x_s1))
	`PSB_ASSERT_IMP(a_pop_needs_room, clk, arst_n, pop, !(out_valid_q && out_stall))

endmodule

`default_nettype wire

>>> hw/rtl/palette_scaled_rgb565_blit_top.sv
// indexed-color pixel scaler with a 256-entry rgb palette, rgb565 output
// input channel (in_valid / in_stall): cmd 0 stores red, green, blue at
// palette entry color_index; cmd 1 maps src_x, src_y through scale and offset
// into the framebuffer and looks up color_index in the palette
// every item yields exactly one result on the output channel (out_valid /
// out_stall); write_valid is 0 for palette writes and clipped pixels, and then
// byte_address and pixel565 read 0
// config channel (cfg_valid / cfg_ready): cfg_ready is always high, cfg_index
// selects the register, indexes past the last register are ignored
// an item passes through a queue slot, multiply stage, clip stage, address
// stage and output register before its result is valid
// throughput: one item per cycle when not stalled; the palette ram takes one
// write and one read per cycle and the back pipeline moves one item per cycle
// a 4-entry queue decouples the input side; in_stall rises when it is full
// out_stall with a result waiting freezes the back pipeline; the queue keeps
// taking items until full
// reset: registers return to defaults, queue and pipeline empty; palette
// contents are undefined until written
`default_nettype none

module palette_scaled_rgb565_blit_top (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           in_valid,
	output      logic                           in_stall,
	input  wire logic                           cmd,
	input  wire logic [psb_pkg::IDX_W-1:0]      color_index,
	input  wire logic [psb_pkg::COMP_W-1:0]     red,
	input  wire logic [psb_pkg::COMP_W-1:0]     green,
	input  wire logic [psb_pkg::COMP_W-1:0]     blue,
	input  wire logic [psb_pkg::SX_W-1:0]       src_x,
	input  wire logic [psb_pkg::SY_W-1:0]       src_y,
	output      logic                           out_valid,
	input  wire logic                           out_stall,
	output      logic                           write_valid,
	output      logic [psb_pkg::ADDR_W-1:0]     byte_address,
	output      logic [psb_pkg::PIX_W-1:0]      pixel565,
	input  wire logic                           cfg_valid,
	output      logic                           cfg_ready,
	input  wire logic [psb_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [psb_pkg::CFG_DATA_W-1:0] cfg_data
);
	import psb_pkg::*;

	cfg_t  cfg_q;
	logic  q_full;
	logic  q_not_empty;
	logic  push;
	logic  pop;
	item_t push_item;
	item_t head;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.scale_q8      <= SCALE_RST;
			cfg_q.x_offset_q8   <= '0;
			cfg_q.y_offset_q8   <= '0;
			cfg_q.screen_width  <= SCR_W_RST;
			cfg_q.screen_height <= SCR_H_RST;
			cfg_q.pan_x         <= '0;
			cfg_q.pan_y         <= '0;
			cfg_q.line_bytes    <= LB_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_SCALE:      cfg_q.scale_q8      <= cfg_data[SCALE_W-1:0];
				REG_X_OFFSET:   cfg_q.x_offset_q8   <= cfg_data[OFS_W-1:0];
				REG_Y_OFFSET:   cfg_q.y_offset_q8   <= cfg_data[OFS_W-1:0];
				REG_SCR_WIDTH:  cfg_q.screen_width  <= cfg_data[SCR_W-1:0];
				REG_SCR_HEIGHT: cfg_q.screen_height <= cfg_data[SCR_W-1:0];
				REG_PAN_X:      cfg_q.pan_x         <= cfg_data[PAN_W-1:0];
				REG_PAN_Y:      cfg_q.pan_y         <= cfg_data[PAN_W-1:0];
				REG_LINE_BYTES: cfg_q.line_bytes    <= cfg_data[LB_W-1:0];
				default: begin
				end
			endcase
		end
	end

	psb_front u_front (
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.cmd        (cmd),
		.color_index(color_index),
		.red        (red),
		.green      (green),
		.blue       (blue),
		.src_x      (src_x),
		.src_y      (src_y),
		.q_full     (q_full),
		.push       (push),
		.push_item  (push_item)
	);

	psb_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_item(push_item),
		.full     (q_full),
		.not_empty(q_not_empty),
		.pop      (pop),
		.head     (head)
	);

	psb_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_q),
		.q_valid     (q_not_empty),
		.head        (head),
		.pop         (pop),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.write_valid (write_valid),
		.byte_address(byte_address),
		.pixel565    (pixel565)
	);

endmodule

`default_nettype wire
